// File: hdl/zcpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-crossing pitch counter package
// Shared widths, codes, reference table and controller/datapath types.
// ----------------------------------------------------------------------------
package zcpc_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W   = 10;
  localparam int CROSS_W    = 16;
  localparam int DEV_W      = 17;
  localparam int SEL_W      = 3;
  localparam int REF_W      = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam int DIV_CNT_W  = $clog2(SAMPLE_W);

  // Defaults for the top-level parameters.
  localparam int COUNT_BITS_DEF   = 32;
  localparam int STRING_COUNT_DEF = 6;

  // Input command codes.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_NOISE_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STRING_SELECT   = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [SAMPLE_W-1:0] NOISE_THRESHOLD_RST = 10'd32;
  localparam logic [SEL_W-1:0]    STRING_SELECT_RST   = 3'd0;

  // Reference crossing count per string, low E to high e.
  function automatic logic [REF_W-1:0] ref_count(input logic [3:0] idx);
    logic [REF_W-1:0] val;
    case (idx)
      4'd0:    val = 8'd115;
      4'd1:    val = 8'd154;
      4'd2:    val = 8'd204;
      4'd3:    val = 8'd183;
      4'd4:    val = 8'd229;
      4'd5:    val = 8'd154;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_sample;
    logic div_init;
    logic div_step;
    logic cross_update;
    logic report_load;
  } zcpc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
  } zcpc_sts_t;

endpackage

// File: hdl/zcpc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-crossing pitch counter input channel
// Carries samples and frame ticks with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface zcpc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [zcpc_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink (input valid, input cmd, input sample, output ready);
endinterface

// File: hdl/zcpc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-crossing pitch counter result channel
// Carries one frame report per transfer with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface zcpc_out_if;
  logic                               valid;
  logic                               ready;
  logic [zcpc_pkg::CROSS_W-1:0]       crossing_count;
  logic [zcpc_pkg::SAMPLE_W-1:0]      signal_span;
  logic                               signal_present;
  logic signed [zcpc_pkg::DEV_W-1:0]  tuning_deviation;
  logic [zcpc_pkg::SAMPLE_W-1:0]      mean_level;

  modport source (output valid, output crossing_count, output signal_span,
                  output signal_present, output tuning_deviation,
                  output mean_level, input ready);
  modport sink (input valid, input crossing_count, input signal_span,
                input signal_present, input tuning_deviation,
                input mean_level, output ready);
endinterface

// File: hdl/zcpc_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-crossing pitch counter configuration channel
// Register writes: index and data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface zcpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [zcpc_pkg::CFG_ADDR_W-1:0] index;
  logic [zcpc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/zcpc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-crossing pitch counter datapath
// Frame statistics, running total, serial mean divider and report register.
// ----------------------------------------------------------------------------
module zcpc_datapath #(
  parameter int COUNT_BITS   = zcpc_pkg::COUNT_BITS_DEF,
  parameter int STRING_COUNT = zcpc_pkg::STRING_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  zcpc_pkg::zcpc_cmd_t                cmd,
  output zcpc_pkg::zcpc_sts_t                sts,
  input  logic [zcpc_pkg::SAMPLE_W-1:0]      sample,
  input  logic                               cfg_write,
  input  logic [zcpc_pkg::CFG_ADDR_W-1:0]    cfg_index,
  input  logic [zcpc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [zcpc_pkg::CROSS_W-1:0]       crossing_count,
  output logic [zcpc_pkg::SAMPLE_W-1:0]      signal_span,
  output logic                               signal_present,
  output logic signed [zcpc_pkg::DEV_W-1:0]  tuning_deviation,
  output logic [zcpc_pkg::SAMPLE_W-1:0]      mean_level
);

  localparam int SW  = zcpc_pkg::SAMPLE_W;
  localparam int CW  = COUNT_BITS;
  localparam int TW  = SW + CW;
  localparam int XW  = zcpc_pkg::CROSS_W;
  localparam int DW  = zcpc_pkg::DEV_W;
  localparam int DCW = zcpc_pkg::DIV_CNT_W;
  localparam logic [SW:0]    MIN_RST    = (SW+1)'(1) << SW;
  localparam logic [XW-1:0]  CROSS_MAX  = '1;
  localparam logic [3:0]     LAST_STR   = 4'(STRING_COUNT - 1);
  localparam logic [DCW-1:0] DIV_LAST   = DCW'(SW - 1);

  // Configuration registers.
  logic [SW-1:0]                  thr_r;
  logic [zcpc_pkg::SEL_W-1:0]     sel_r;

  // Persistent and frame state.
  logic [TW-1:0]   total_r;
  logic [CW-1:0]   count_r;
  logic [SW-1:0]   mean_r;
  logic [SW-1:0]   prev_r;
  logic [SW-1:0]   max_r;
  logic [SW:0]     min_r;
  logic [XW-1:0]   cross_r;
  logic            has_r;
  logic [SW-1:0]   hold_r;

  // Divider.
  logic [CW-1:0]   rem_r;
  logic [SW-1:0]   quo_r;
  logic [DCW-1:0]  div_cnt_r;

  // Report register.
  logic [XW-1:0]   rep_cross_r;
  logic [SW-1:0]   rep_span_r;
  logic            rep_present_r;
  logic [DW-1:0]   rep_dev_r;
  logic [SW-1:0]   rep_mean_r;

  logic [CW-1:0]   count_inc;
  logic [CW:0]     trial;
  logic [CW:0]     diff;
  logic            ge;
  logic [SW-1:0]   span;
  logic [SW-1:0]   rep_span;
  logic            crossed;
  logic [3:0]      ref_idx;
  logic [DW-1:0]   dev;

  always_comb begin
    count_inc = count_r + CW'(1);
    trial     = {rem_r, quo_r[SW-1]};
    diff      = trial - {1'b0, count_r};
    ge        = (trial >= {1'b0, count_r});
    span      = ({1'b0, max_r} >= min_r) ? SW'({1'b0, max_r} - min_r) : '0;
    rep_span  = has_r ? span : '0;
    crossed   = ((prev_r < quo_r) && (hold_r >= quo_r)) ||
                ((prev_r > quo_r) && (hold_r <= quo_r));
    if (int'(sel_r) >= STRING_COUNT) begin
      ref_idx = LAST_STR;
    end else begin
      ref_idx = 4'(sel_r);
    end
    dev = {1'b0, cross_r} - DW'(zcpc_pkg::ref_count(ref_idx));
  end

  assign sts.div_last = (div_cnt_r == DIV_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= zcpc_pkg::NOISE_THRESHOLD_RST;
      sel_r   <= zcpc_pkg::STRING_SELECT_RST;
      total_r <= '0;
      count_r <= '0;
      mean_r  <= '0;
      prev_r  <= '0;
      max_r   <= '0;
      min_r   <= MIN_RST;
      cross_r <= '0;
      has_r   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          zcpc_pkg::REG_NOISE_THRESHOLD: thr_r <= cfg_data[SW-1:0];
          zcpc_pkg::REG_STRING_SELECT:   sel_r <= cfg_data[zcpc_pkg::SEL_W-1:0];
          default: ;
        endcase
      end
      if (cmd.take_sample) begin
        if (sample > max_r) begin
          max_r <= sample;
        end
        if ({1'b0, sample} < min_r) begin
          min_r <= {1'b0, sample};
        end
        has_r <= 1'b1;
        // On count wrap the average restarts from a single, zero-weighted sample.
        if (count_inc == '0) begin
          count_r <= CW'(1);
          total_r <= '0;
        end else begin
          count_r <= count_inc;
          total_r <= total_r + TW'(sample);
        end
      end
      if (cmd.cross_update) begin
        mean_r <= quo_r;
        prev_r <= hold_r;
        if ((span > thr_r) && crossed && (cross_r != CROSS_MAX)) begin
          cross_r <= cross_r + XW'(1);
        end
      end
      if (cmd.report_load) begin
        cross_r <= '0;
        max_r   <= '0;
        min_r   <= MIN_RST;
        has_r   <= 1'b0;
      end
    end
  end

  // Payload registers: sample hold, restoring divider and report.
  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      hold_r <= sample;
    end
    if (cmd.div_init) begin
      // The quotient never exceeds the sample range, so the upper part of the
      // total is already below the divisor.
      rem_r     <= total_r[TW-1:SW];
      quo_r     <= total_r[SW-1:0];
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= ge ? diff[CW-1:0] : trial[CW-1:0];
      quo_r     <= {quo_r[SW-2:0], ge};
      div_cnt_r <= div_cnt_r + DCW'(1);
    end
    if (cmd.report_load) begin
      rep_cross_r   <= cross_r;
      rep_span_r    <= rep_span;
      rep_present_r <= (rep_span > thr_r);
      rep_dev_r     <= dev;
      rep_mean_r    <= mean_r;
    end
  end

  assign crossing_count   = rep_cross_r;
  assign signal_span      = rep_span_r;
  assign signal_present   = rep_present_r;
  assign tuning_deviation = $signed(rep_dev_r);
  assign mean_level       = rep_mean_r;

endmodule

// File: hdl/zcpc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Zero-crossing pitch counter controller
// Sequences sample update, mean division, crossing check and frame report.
// ----------------------------------------------------------------------------
module zcpc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output zcpc_pkg::zcpc_cmd_t  cmd,
  input  zcpc_pkg::zcpc_sts_t  sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_DIVIDE,
    ST_CROSS,
    ST_REPORT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == zcpc_pkg::CMD_TICK) begin
            state_nxt = ST_REPORT;
          end else begin
            cmd.take_sample = 1'b1;
            state_nxt       = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_CROSS;
        end
      end
      ST_CROSS: begin
        cmd.cross_update = 1'b1;
        state_nxt        = ST_IDLE;
      end
      ST_REPORT: begin
        if (out_free) begin
          cmd.report_load = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cmd.report_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_sample_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_cmd == zcpc_pkg::CMD_SAMPLE)) |=> (state_r == ST_INIT))
    else $error("sample transfer did not start the mean division");

  a_divide_ends_in_cross: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIVIDE) && sts.div_last) |=> (state_r == ST_CROSS))
    else $error("divider finished but crossing check did not follow");

  a_report_presents_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.report_load |=> out_valid_r)
    else $error("report load did not present a result");

  a_result_from_report: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_REPORT))
    else $error("result appeared outside the report state");
`endif

endmodule

// File: hdl/zero_crossing_pitch_counter.sv
`timescale 1ns / 1ps
// A sample transfer occupies the block while it updates the statistics, loads the divider,
// runs the restoring divider over every mean bit and then checks for a crossing.
// A frame tick waits in the report state until the result slot is free, then loads the report
// and registers the result valid. No new sample is taken until the bit-serial mean divider
// and the crossing check are through with the last one. Synchronous active-low reset clears
// all statistics and the mean and restores the register defaults.
// ----------------------------------------------------------------------------
// Zero-crossing pitch counter
// Counts crossings of the running mean per frame and reports pitch statistics.
// ----------------------------------------------------------------------------
module zero_crossing_pitch_counter #(
  parameter int COUNT_BITS   = zcpc_pkg::COUNT_BITS_DEF,
  parameter int STRING_COUNT = zcpc_pkg::STRING_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  zcpc_in_if.sink     in_if,
  zcpc_out_if.source  out_if,
  zcpc_cfg_if.sink    cfg_if
);

  // Command and status between the controller and the datapath.
  zcpc_pkg::zcpc_cmd_t cmd;
  zcpc_pkg::zcpc_sts_t sts;

  // Configuration writes are always taken; they are expected only while the
  // block is idle. The block does not enforce this; a write can disturb an item in flight.
  assign cfg_if.ready = 1'b1;

  // The controller accepts one item at a time. A sample runs through the
  // statistics update, the serial divider and the crossing check; a tick
  // waits for the result register and then loads the report, clearing the
  // frame statistics in the same cycle. A waiting result does not block
  // further samples.
  zcpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_cmd    (in_if.cmd),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the running total (wide enough never to wrap), the
  // sample count, the mean, the frame min/max and the crossing counter, plus
  // the report register that drives the result channel.
  zcpc_datapath #(
    .COUNT_BITS   (COUNT_BITS),
    .STRING_COUNT (STRING_COUNT)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .sample           (in_if.sample),
    .cfg_write        (cfg_if.valid),
    .cfg_index        (cfg_if.index),
    .cfg_data         (cfg_if.data),
    .crossing_count   (out_if.crossing_count),
    .signal_span      (out_if.signal_span),
    .signal_present   (out_if.signal_present),
    .tuning_deviation (out_if.tuning_deviation),
    .mean_level       (out_if.mean_level)
  );

endmodule
